@@ rtl/htd_pkg.sv @@
// shared types and constants of the huffman node-table decoder
`default_nettype none

package htd_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int LEN_W          = 32;
    localparam int BRANCH_W       = 9;
    localparam int NODE_W         = 8;
    localparam int NODE_DEPTH     = 256;
    localparam int ENTRY_W        = 2 * BRANCH_W;
    localparam int BYTE_W         = 8;

    localparam logic [NODE_W-1:0] ROOT_NODE = 8'd254;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // one decoded byte offered by the walker to the output stage
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              chunk_done;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/huffman_tree_table_decoder.sv @@
// huffman node-table decoder: table walk plus registered output stage
//
// Input channel i_valid/o_ready carries one request: load a table node
// (cmd 0), start a chunk (cmd 1, takes the output length, clears the count
// and returns the walk to root node 254) or a compressed byte (cmd 2).
// Output channel o_valid/i_ready carries decoded bytes with o_last on the
// final byte of each compressed byte and o_chunk_done on the byte that
// brings the count to the chunk length.
// Load, start and unused requests are taken while idle. A data byte is
// accepted, then walked one bit per cycle (eight, fewer when the chunk
// completes inside the byte) through the single node-table read port
// while no leaf waits on a stalled output, and then hands off its final
// decoded byte, if any; no new request is taken until then.
// A data byte accepted once the chunk is complete is dropped and
// gives no output. Each decoded byte waits in the walker until the next
// leaf or the final hand-off. When the receiver stalls, the walk holds
// on the next leaf until the output register frees up. Reset clears
// the walk to the root, the count and the length to zero and empties
// the output; the node table keeps its contents and must be loaded
// before use.
`default_nettype none

module huffman_tree_table_decoder #(
    parameter int COUNT_BITS = htd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [htd_pkg::NODE_W-1:0]    i_node_index,
    input  wire logic [htd_pkg::BRANCH_W-1:0]  i_zero_branch,
    input  wire logic [htd_pkg::BRANCH_W-1:0]  i_one_branch,
    input  wire logic [htd_pkg::LEN_W-1:0]     i_out_length,
    input  wire logic [htd_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [htd_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                               o_last,
    output logic                               o_chunk_done
);

    htd_pkg::t_result            res;
    logic                        res_ready;
    logic                        r_out_valid;
    logic [htd_pkg::BYTE_W-1:0]  r_out_byte;
    logic                        r_out_last;
    logic                        r_out_done;

    htd_walker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_node_index  (i_node_index),
        .i_zero_branch (i_zero_branch),
        .i_one_branch  (i_one_branch),
        .i_out_length  (i_out_length),
        .i_data_byte   (i_data_byte),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_byte <= res.out_byte;
            r_out_last <= res.last;
            r_out_done <= res.chunk_done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_last       = r_out_last;
    assign o_chunk_done = r_out_done;

endmodule

`default_nettype wire

@@ rtl/htd_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/htd_walker.sv @@
// command sequencer and one-bit-per-cycle tree walk over the node table, holding on a leaf while the output is full
`default_nettype none

module htd_walker #(
    parameter int COUNT_BITS = htd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [htd_pkg::NODE_W-1:0]    i_node_index,
    input  wire logic [htd_pkg::BRANCH_W-1:0]  i_zero_branch,
    input  wire logic [htd_pkg::BRANCH_W-1:0]  i_one_branch,
    input  wire logic [htd_pkg::LEN_W-1:0]     i_out_length,
    input  wire logic [htd_pkg::BYTE_W-1:0]    i_data_byte,
    output htd_pkg::t_result                   o_res,
    input  wire logic                          i_res_ready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [htd_pkg::NODE_W-1:0]    r_node, n_node;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic [COUNT_BITS-1:0]         r_length, n_length;
    logic [htd_pkg::BYTE_W-1:0]    r_byte, n_byte;
    logic [2:0]                    r_bit, n_bit;
    logic                          r_pend_valid, n_pend_valid;
    logic [htd_pkg::BYTE_W-1:0]    r_pend_byte, n_pend_byte;
    logic                          r_pend_done, n_pend_done;

    logic                          ram_we;
    logic [htd_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [htd_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [htd_pkg::BRANCH_W-1:0]  branch;
    logic                          leaf;
    logic [COUNT_BITS-1:0]         cnt_inc;
    logic                          hit;

    assign ram_wdata = {i_one_branch, i_zero_branch};

    // read address follows the next node so the entry is ready on the next cycle
    htd_ram #(
        .WIDTH (htd_pkg::ENTRY_W),
        .DEPTH (htd_pkg::NODE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_node_index),
        .i_wdata (ram_wdata),
        .i_raddr (n_node),
        .o_rdata (ram_rdata)
    );

    assign branch  = r_byte[r_bit] ? ram_rdata[htd_pkg::ENTRY_W-1:htd_pkg::BRANCH_W]
                                   : ram_rdata[htd_pkg::BRANCH_W-1:0];
    assign leaf    = !branch[htd_pkg::BRANCH_W-1];
    assign cnt_inc = r_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign hit     = (cnt_inc == r_length);

    always_comb begin
        n_state      = r_state;
        n_node       = r_node;
        n_count      = r_count;
        n_length     = r_length;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_done  = r_pend_done;
        ram_we       = 1'b0;
        o_ready      = 1'b0;
        o_res.valid      = 1'b0;
        o_res.out_byte   = r_pend_byte;
        o_res.last       = 1'b0;
        o_res.chunk_done = r_pend_done;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_cmd)
                        htd_pkg::CMD_LOAD: begin
                            ram_we = 1'b1;
                        end
                        htd_pkg::CMD_START: begin
                            n_length = i_out_length[COUNT_BITS-1:0];
                            n_count  = '0;
                            n_node   = htd_pkg::ROOT_NODE;
                        end
                        htd_pkg::CMD_DATA: begin
                            if (r_count < r_length) begin
                                n_byte  = i_data_byte;
                                n_bit   = 3'd0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (leaf) begin
                    // an older decoded byte of this request goes out first, not last
                    if (!r_pend_valid || i_res_ready) begin
                        o_res.valid  = r_pend_valid;
                        n_count      = cnt_inc;
                        n_pend_valid = 1'b1;
                        n_pend_byte  = branch[htd_pkg::BYTE_W-1:0];
                        n_pend_done  = hit;
                        n_node       = htd_pkg::ROOT_NODE;
                        if (hit || r_bit == 3'd7) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_bit = r_bit + 3'd1;
                        end
                    end
                end else begin
                    n_node = branch[htd_pkg::NODE_W-1:0];
                    if (r_bit == 3'd7) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else begin
                    o_res.valid = 1'b1;
                    o_res.last  = 1'b1;
                    if (i_res_ready) begin
                        n_pend_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node       <= htd_pkg::ROOT_NODE;
            r_count      <= '0;
            r_length     <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node       <= n_node;
            r_count      <= n_count;
            r_length     <= n_length;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_bit       <= n_bit;
        r_pend_byte <= n_pend_byte;
        r_pend_done <= n_pend_done;
    end

endmodule

`default_nettype wire

@@ rtl/htd_checker.sv @@
// port-level checks of the huffman node-table decoder, bound to the top level
`default_nettype none

module htd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_ready,
    input wire logic [1:0]                  i_cmd,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [htd_pkg::BYTE_W-1:0]  o_out_byte,
    input wire logic                        o_last,
    input wire logic                        o_chunk_done
);

    // output empties during reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // stalled output keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last)
            && $stable(o_chunk_done))
        else $error("stalled output changed");

    // the completing byte always closes its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chunk_done |-> o_last)
        else $error("chunk done without last");

    // load and start requests leave the decoder ready for another request
    a_cfg_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_cmd == htd_pkg::CMD_LOAD || i_cmd == htd_pkg::CMD_START)
            |=> o_ready)
        else $error("not ready after load or start");

endmodule

bind huffman_tree_table_decoder htd_checker u_htd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_cmd        (i_cmd),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_byte   (o_out_byte),
    .o_last       (o_last),
    .o_chunk_done (o_chunk_done)
);

`default_nettype wire
